/* hw/rtl/pqe_pkg.sv */
package pqe_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned PriW     = 8;
  localparam int unsigned PayW     = 32;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  // one stored entry
  typedef struct packed {
    logic [PriW-1:0] pri;
    logic [PayW-1:0] pay;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;     // take the accepted word
    logic    wr_ins;      // append the captured entry
    logic    st_load;     // latch the result code
    status_e st_code;
    logic    scan_clr;    // read pointer to the first entry
    logic    issue;       // read at the pointer and advance it
    logic    shift_mode;  // issued read feeds the gap closing, not the search
    logic    shift_init;  // read pointer to the entry after the winner
    logic    load_out;    // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    empty;
    logic    ptr_end;     // pointer has reached the fill count
    logic    rd_busy;     // a read is still in flight
    logic    out_free;    // output register can take a word this cycle
  } sts_t;

endpackage

/* hw/rtl/priority_extract_queue.sv */
// bounded priority queue of DEPTH entries held in a single-port-write,
// registered-read memory in arrival order. an insert word appends its
// priority and payload (status inserted) or is dropped when the queue is full
// (status full). a remove word returns the entry of highest priority, the
// oldest among equal ones, and closes the gap (status removed); on an empty
// queue it returns status empty. priority and payload of the result are zero
// unless the status is removed. one word is worked on at a time: an insert,
// a dropped insert or an empty remove goes through the exec and done states
// to the output register, and the next word can be taken once back in idle.
// a remove sweeps the one memory read port once over all entries to find
// the winner and once more over the entries after it to move them down one
// place. the output register lets a finished result wait for the consumer
// while the next word is taken and worked on.
module priority_extract_queue #(
  parameter int unsigned DEPTH = pqe_pkg::DefDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      opcode_i,
  input  logic [pqe_pkg::PriW-1:0]  priority_req_i,
  input  logic [pqe_pkg::PayW-1:0]  payload_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [pqe_pkg::PriW-1:0]  out_priority_o,
  output logic [pqe_pkg::PayW-1:0]  out_payload_o
);

  pqe_pkg::cmd_t cmd;
  pqe_pkg::sts_t sts;

  // sequencer: accept, decide, sweep for the maximum, close the gap, report
  pqe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry store, fill count, running maximum and output register
  pqe_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .priority_req_i (priority_req_i),
    .payload_i      (payload_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_payload_o  (out_payload_o)
  );

endmodule

/* hw/rtl/pqe_ctrl.sv */
module pqe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pqe_pkg::sts_t sts_i,
  output pqe_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st_code = pqe_pkg::ST_INSERTED;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.st_load = 1'b1;
        if (sts_i.op == pqe_pkg::OP_INSERT) begin
          if (sts_i.full) begin
            cmd_o.st_code = pqe_pkg::ST_FULL;
          end else begin
            cmd_o.st_code = pqe_pkg::ST_INSERTED;
            cmd_o.wr_ins  = 1'b1;
          end
          state_d = S_DONE;
        end else if (sts_i.empty) begin
          cmd_o.st_code = pqe_pkg::ST_EMPTY;
          state_d = S_DONE;
        end else begin
          cmd_o.st_code  = pqe_pkg::ST_REMOVED;
          cmd_o.scan_clr = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.ptr_end) begin
          cmd_o.issue = 1'b1;
        end else if (!sts_i.rd_busy) begin
          cmd_o.shift_init = 1'b1;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!sts_i.ptr_end) begin
          cmd_o.issue      = 1'b1;
          cmd_o.shift_mode = 1'b1;
        end else if (!sts_i.rd_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/pqe_dp.sv */
module pqe_dp #(
  parameter int unsigned DEPTH = pqe_pkg::DefDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      opcode_i,
  input  logic [pqe_pkg::PriW-1:0]  priority_req_i,
  input  logic [pqe_pkg::PayW-1:0]  payload_i,
  input  pqe_pkg::cmd_t             cmd_i,
  output pqe_pkg::sts_t             sts_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [pqe_pkg::PriW-1:0]  out_priority_o,
  output logic [pqe_pkg::PayW-1:0]  out_payload_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pqe_pkg::entry_t  mem [DEPTH];
  pqe_pkg::entry_t  rdata_q;
  pqe_pkg::entry_t  req_q;
  pqe_pkg::entry_t  best_q;
  pqe_pkg::entry_t  wr_data;
  pqe_pkg::opcode_e op_q;
  pqe_pkg::status_e res_q;
  logic [AW-1:0]    best_idx_q;
  logic [AW-1:0]    rd_idx_q;
  logic [AW-1:0]    wr_addr;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    ptr_q;
  logic             rd_vld_q;
  logic             rd_shift_q;
  logic             wr_en;
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [pqe_pkg::PriW-1:0] opri_q;
  logic [pqe_pkg::PayW-1:0] opay_q;

  // entry store, one write and one registered read a cycle
  assign wr_en   = cmd_i.wr_ins | (rd_vld_q & rd_shift_q);
  assign wr_addr = cmd_i.wr_ins ? count_q[AW-1:0] : (rd_idx_q - AW'(1));
  assign wr_data = cmd_i.wr_ins ? req_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[ptr_q[AW-1:0]];
  end

  // captured request and running maximum
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q.pri <= priority_req_i;
      req_q.pay <= payload_i;
      op_q      <= pqe_pkg::opcode_e'(opcode_i);
    end
    if (cmd_i.st_load) begin
      res_q <= cmd_i.st_code;
    end
    // strict compare keeps the oldest of equal priorities
    if (rd_vld_q && !rd_shift_q &&
        ((rd_idx_q == '0) || (rdata_q.pri > best_q.pri))) begin
      best_q     <= rdata_q;
      best_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ptr_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_shift_q <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      rd_vld_q   <= cmd_i.issue;
      rd_shift_q <= cmd_i.shift_mode;
      rd_idx_q   <= ptr_q[AW-1:0];
      if (cmd_i.scan_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.shift_init) begin
        ptr_q <= CW'(best_idx_q) + CW'(1);
      end else if (cmd_i.issue) begin
        ptr_q <= ptr_q + CW'(1);
      end
      if (cmd_i.wr_ins) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.load_out && (res_q == pqe_pkg::ST_REMOVED)) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q <= res_q;
      if (res_q == pqe_pkg::ST_REMOVED) begin
        opri_q <= best_q.pri;
        opay_q <= best_q.pay;
      end else begin
        opri_q <= '0;
        opay_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = opri_q;
  assign out_payload_o  = opay_q;

  assign sts_o.op       = op_q;
  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.ptr_end  = (ptr_q == count_q);
  assign sts_o.rd_busy  = rd_vld_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

/* hw/rtl/pqe_checker.sv */
module pqe_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [1:0]                status_o,
  input logic [pqe_pkg::PriW-1:0]  out_priority_o,
  input logic [pqe_pkg::PayW-1:0]  out_payload_o
);

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word withdrawn while stalled");

  // a held result does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(status_o) && $stable(out_priority_o) && $stable(out_payload_o))
    else $error("result word changed while stalled");

  // only a removal carries an entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pqe_pkg::ST_REMOVED) |->
      (out_priority_o == '0) && (out_payload_o == '0))
    else $error("non-removal result carries data");

  // one word at a time: busy right after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");

endmodule

bind priority_extract_queue pqe_checker u_pqe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .out_priority_o (out_priority_o),
  .out_payload_o  (out_payload_o)
);

/* tb/tb_priority_extract_queue.sv */
`timescale 1ns / 1ps

module tb_priority_extract_queue;

  localparam int unsigned Depth       = pqe_pkg::DefDepth;
  localparam int unsigned PriW        = pqe_pkg::PriW;
  localparam int unsigned PayW        = pqe_pkg::PayW;
  localparam int unsigned ClkPeriodNs = 12;
  localparam int unsigned HoldCycles  = 400;   // long receiver hold-off
  localparam int unsigned SettleCycles = 80;   // idle time after the drain, longer than a full remove sweep
  localparam int unsigned TimeoutNs   = 12_000_000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;
  typedef enum int {PRI_FULL, PRI_NARROW, PRI_TOP, PRI_EXTREME} pri_style_e;

  // one result word as the queue should return it
  typedef struct packed {
    pqe_pkg::status_e status;
    logic [PriW-1:0]  pri;
    logic [PayW-1:0]  pay;
  } result_t;

  logic            clk_i          = 1'b0;
  logic            rst_ni         = 1'b0;
  logic            in_valid_i     = 1'b0;
  logic            opcode_i       = 1'b0;
  logic [PriW-1:0] priority_req_i = '0;
  logic [PayW-1:0] payload_i      = '0;
  logic            out_stall_i    = 1'b0;
  logic            in_stall_o;
  logic            out_valid_o;
  logic [1:0]      status_o;
  logic [PriW-1:0] out_priority_o;
  logic [PayW-1:0] out_payload_o;

  // shadow copy of the queue contents, oldest first
  logic [PriW-1:0] shadow_pri [Depth];
  logic [PayW-1:0] shadow_pay [Depth];
  int unsigned     shadow_count = 0;

  result_t     pending_results[$];
  int unsigned mismatches     = 0;
  int unsigned words_in       = 0;
  int unsigned words_out      = 0;
  int unsigned n_inserted     = 0;
  int unsigned n_dropped      = 0;
  int unsigned n_removed      = 0;
  int unsigned n_empty        = 0;
  int unsigned in_held_cycles = 0;

  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_request   = 1'b0;

  priority_extract_queue #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .priority_req_i (priority_req_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_payload_o  (out_payload_o)
  );

  initial begin
    forever #(ClkPeriodNs / 2) clk_i = ~clk_i;
  end

  // applies one request to the shadow queue and returns the word it must produce
  function automatic result_t serve_request(pqe_pkg::opcode_e op, logic [PriW-1:0] pri,
                                            logic [PayW-1:0] pay);
    result_t     res;
    int unsigned best;
    res = '{status: pqe_pkg::ST_INSERTED, pri: '0, pay: '0};
    if (op == pqe_pkg::OP_INSERT) begin
      if (shadow_count >= Depth) begin
        res.status = pqe_pkg::ST_FULL;
      end else begin
        shadow_pri[shadow_count] = pri;
        shadow_pay[shadow_count] = pay;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = pqe_pkg::ST_EMPTY;
    end else begin
      // strict compare keeps the oldest among equal priorities
      best = 0;
      for (int unsigned k = 1; k < shadow_count; k++) begin
        if (shadow_pri[k] > shadow_pri[best]) best = k;
      end
      res.status = pqe_pkg::ST_REMOVED;
      res.pri    = shadow_pri[best];
      res.pay    = shadow_pay[best];
      for (int unsigned k = best; k + 1 < shadow_count; k++) begin
        shadow_pri[k] = shadow_pri[k + 1];
        shadow_pay[k] = shadow_pay[k + 1];
      end
      shadow_count--;
    end
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [PriW-1:0] pick_priority(pri_style_e style);
    case (style)
      PRI_NARROW:  return PriW'($urandom_range(0, 3));
      PRI_TOP:     return PriW'($urandom_range(252, 255));
      PRI_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default:     return PriW'($urandom_range(0, 255));
    endcase
  endfunction

  // offers one word, holds it steady until taken, then maybe idles
  task automatic send_word(pqe_pkg::opcode_e op, logic [PriW-1:0] pri,
                           logic [PayW-1:0] pay);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    priority_req_i <= pri;
    payload_i      <= pay;
    do @(posedge clk_i); while (in_stall_o);
    words_in++;
    gap = sender_idles ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid and wait for every outstanding word to come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // empty remove, field extremes, ordering by priority and age among equals
  task automatic test_edges();
    send_word(pqe_pkg::OP_REMOVE, '0, '0);
    send_word(pqe_pkg::OP_INSERT, '0, '0);
    send_word(pqe_pkg::OP_INSERT, '1, '1);
    send_word(pqe_pkg::OP_INSERT, 8'h80, 32'h0000_0001);
    repeat (4) send_word(pqe_pkg::OP_REMOVE, '0, '0);
    send_word(pqe_pkg::OP_INSERT, 8'd7, 32'haaaa_0001);
    send_word(pqe_pkg::OP_INSERT, 8'd7, 32'haaaa_0002);
    send_word(pqe_pkg::OP_INSERT, 8'd3, 32'h5555_0003);
    send_word(pqe_pkg::OP_INSERT, 8'd7, 32'haaaa_0004);
    repeat (4) send_word(pqe_pkg::OP_REMOVE, 8'hff, 32'hffff_ffff);
    // remove fields are don't-care, the result must still read zero
    send_word(pqe_pkg::OP_REMOVE, 8'h5a, 32'hdead_beef);
  endtask

  // fill to the brim, insert into a full queue, then drain past empty
  task automatic test_full_drop();
    for (int unsigned k = 0; k < Depth; k++) begin
      send_word(pqe_pkg::OP_INSERT, PriW'(k * 13), $urandom());
    end
    send_word(pqe_pkg::OP_INSERT, '1, $urandom());
    send_word(pqe_pkg::OP_INSERT, '0, $urandom());
    send_word(pqe_pkg::OP_REMOVE, '0, '0);
    send_word(pqe_pkg::OP_INSERT, '1, $urandom());
    send_word(pqe_pkg::OP_INSERT, 8'd1, $urandom());
    repeat (Depth + 1) send_word(pqe_pkg::OP_REMOVE, '0, '0);
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_request   = 1'b1;
    for (int unsigned k = 0; k < 48; k++) begin
      send_word(($urandom_range(0, 2) != 0) ? pqe_pkg::OP_INSERT : pqe_pkg::OP_REMOVE,
                pick_priority(PRI_FULL), $urandom());
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // bursts that lean towards filling, draining or neither, with varied priorities
  task automatic test_random(int unsigned n_words);
    int unsigned sent;
    int unsigned burst;
    int unsigned insert_pct;
    mix_e        mix;
    pri_style_e  style;
    sent = 0;
    while (sent < n_words) begin
      mix   = mix_e'($urandom_range(0, 2));
      style = pri_style_e'($urandom_range(0, 3));
      burst = $urandom_range(10, 40);
      case (mix)
        MIX_FILL:  insert_pct = 75;
        MIX_DRAIN: insert_pct = 25;
        default:   insert_pct = 50;
      endcase
      // some bursts run flat out on one side or both
      sender_idles   = ($urandom_range(0, 4) != 0);
      receiver_idles = ($urandom_range(0, 4) != 0);
      for (int unsigned k = 0; k < burst && sent < n_words; k++) begin
        send_word(($urandom_range(0, 99) < insert_pct) ? pqe_pkg::OP_INSERT
                                                       : pqe_pkg::OP_REMOVE,
                  pick_priority(style), $urandom());
        sent++;
      end
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // result side: random stall runs, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HoldCycles;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (receiver_idles && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // predict on every accepted request, check every accepted result in order
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) in_held_cycles++;
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(serve_request(pqe_pkg::opcode_e'(opcode_i),
                                                priority_req_i, payload_i));
      end
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        case (status_o)
          pqe_pkg::ST_INSERTED: n_inserted++;
          pqe_pkg::ST_FULL:     n_dropped++;
          pqe_pkg::ST_REMOVED:  n_removed++;
          default:              n_empty++;
        endcase
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result word: status %0d pri %0d payload %h",
                     status_o, out_priority_o, out_payload_o);
          end
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status || out_priority_o !== want.pri ||
              out_payload_o !== want.pay) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result word %0d: expected status %0d pri %0d payload %h, got status %0d pri %0d payload %h",
                       words_out, want.status, want.pri, want.pay,
                       status_o, out_priority_o, out_payload_o);
            end
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edges();
    wait_drained();
    test_full_drop();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random(500);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d requests sent, %0d results: %0d inserted, %0d dropped as full, %0d removed, %0d empty",
             words_in, words_out, n_inserted, n_dropped, n_removed, n_empty);
    $display("input held off for %0d cycles, %0d mismatches, %0d results outstanding",
             in_held_cycles, mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS priority_extract_queue");
    end else begin
      $display("FAIL priority_extract_queue");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(TimeoutNs);
    $display("timed out with %0d results outstanding", pending_results.size());
    $display("FAIL priority_extract_queue");
    $finish;
  end

endmodule
